// ===== rtl/core/scrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scrp_pkg;

    // row mask storage
    localparam int MaskRows  = 256;
    localparam int MaskWords = (MaskRows + 63) / 64;
    localparam int MaskBits  = MaskWords * 64;
    localparam int MaskIdxW  = $clog2(MaskBits);

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgMaxRow    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCellCap   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgMaskBytes = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgMaskWord0 = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgMaskWordN = 3'd6;

    // record types
    localparam logic [14:0] RecRow    = 15'h0000;
    localparam logic [14:0] RecRk     = 15'h0002;
    localparam logic [14:0] RecBool   = 15'h0004;
    localparam logic [14:0] RecReal   = 15'h0005;
    localparam logic [14:0] RecStr    = 15'h0007;
    localparam logic [14:0] RecFmlStr = 15'h0008;
    localparam logic [14:0] RecFmlNum = 15'h0009;

    // cell kinds
    localparam logic [2:0] KindNumber  = 3'd1;
    localparam logic [2:0] KindStrIdx  = 3'd2;
    localparam logic [2:0] KindBoolean = 3'd3;
    localparam logic [2:0] KindFmlStr  = 3'd4;

    localparam logic [63:0] DblOne     = 64'h3FF0_0000_0000_0000;
    localparam logic [10:0] ExpInfNan  = 11'h7FF;
    localparam logic [12:0] ExpBiasInt = 13'd1075;
    localparam int          DecDivisor = 100;

    // job queue
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [2:0] {
        PH_TYPE0,
        PH_TYPE1,
        PH_SIZE,
        PH_DATA,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        OP_RAW,
        OP_RK,
        OP_UINT
    } t_conv_op;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_NORM,
        CV_DIV,
        CV_ALIGN,
        CV_ROUND,
        CV_DONE
    } t_cv_state;

    typedef struct packed {
        logic        has_cell;
        logic        has_sum;
        logic [31:0] row;
        logic [31:0] column;
        logic [2:0]  kind;
        t_conv_op    op;
        logic [63:0] value;
        logic [31:0] offset;
        logic [31:0] blen;
        logic [31:0] total;
    } t_job;

    typedef struct packed {
        logic        start;
        logic        take;
        t_conv_op    op;
        logic [31:0] src;
    } t_conv_req;

    typedef struct packed {
        logic        valid;
        logic [63:0] value;
    } t_conv_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/scrp_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface scrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scrp_cell_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface scrp_cell_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [31:0] cell_row;
    logic [31:0] cell_column;
    logic [2:0]  cell_kind;
    logic [63:0] value_bits;
    logic [31:0] text_offset;
    logic [31:0] text_byte_length;
    logic [31:0] total_cells;
    logic        is_last;

    modport source (
        output valid, output is_summary, output cell_row, output cell_column,
        output cell_kind, output value_bits, output text_offset,
        output text_byte_length, output total_cells, output is_last, input ready
    );
    modport sink (
        input valid, input is_summary, input cell_row, input cell_column,
        input cell_kind, input value_bits, input text_offset,
        input text_byte_length, input total_cells, input is_last, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/scrp_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scrp_conv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire scrp_pkg::t_conv_req i_req,
    output scrp_pkg::t_conv_rsp      o_rsp
);
    import scrp_pkg::*;

    t_cv_state r_state, n_state;

    logic               r_sign, n_sign;
    logic [52:0]        r_m, n_m;
    logic signed [12:0] r_be, n_be;
    logic               r_div, n_div;
    logic [63:0]        r_n, n_n;
    logic [55:0]        r_q, n_q;
    logic [6:0]         r_r, n_r;
    logic [2:0]         r_cnt, n_cnt;
    logic [53:0]        r_z, n_z;
    logic               r_st, n_st;
    logic [10:0]        r_ef, n_ef;
    logic [63:0]        r_value, n_value;

    // start decode
    logic        st_direct;
    logic [63:0] st_val;
    logic        st_sign;
    logic [52:0] st_m;
    logic [12:0] st_be;
    logic        st_div;
    logic [29:0] st_mag;
    logic [63:0] st_fb;

    // division digits
    logic [10:0] step0, step1;

    // align
    logic               al_sel;
    logic [53:0]        al_z;
    logic               al_st;
    logic signed [12:0] al_eo;
    logic [5:0]         al_sh;
    logic [53:0]        al_mask;
    logic               up;

    // one radix-16 digit of a divide by the decimal constant
    function automatic logic [10:0] dig_step(input logic [6:0] rem, input logic [3:0] dig);
        logic [10:0] t;
        logic [3:0]  q;
        begin
            t = {rem, dig};
            q = '0;
            for (int j = 1; j < 16; j++) begin
                if (t >= 11'(DecDivisor * j)) q = 4'(j);
            end
            dig_step = {q, 7'(t - 11'(q) * 11'(DecDivisor))};
        end
    endfunction

    always_comb begin
        st_direct = 1'b0;
        st_val    = '0;
        st_sign   = 1'b0;
        st_m      = '0;
        st_be     = ExpBiasInt;
        st_div    = 1'b0;
        st_mag    = '0;
        st_fb     = {i_req.src[31:2], 2'b00, 32'b0};
        unique case (i_req.op)
            OP_UINT: begin
                st_m      = 53'(i_req.src);
                st_direct = (i_req.src == 32'd0);
            end
            OP_RK: begin
                st_div = i_req.src[0];
                if (i_req.src[1]) begin
                    st_sign   = i_req.src[31];
                    st_mag    = i_req.src[31] ? 30'(~i_req.src[31:2] + 30'd1) : i_req.src[31:2];
                    st_m      = 53'(st_mag);
                    st_direct = (st_mag == 30'd0);
                end else if (!i_req.src[0]) begin
                    st_direct = 1'b1;
                    st_val    = st_fb;
                end else if (st_fb[62:52] == ExpInfNan) begin
                    // infinity passes, nan comes out quiet
                    st_direct = 1'b1;
                    st_val    = (st_fb[51:0] == 52'd0) ? st_fb : (st_fb | (64'd1 << 51));
                end else if (st_fb[62:0] == 63'd0) begin
                    st_direct = 1'b1;
                    st_val    = st_fb;
                end else if (st_fb[62:52] == 11'd0) begin
                    st_sign = st_fb[63];
                    st_m    = {1'b0, st_fb[51:0]};
                    st_be   = 13'd1;
                end else begin
                    st_sign = st_fb[63];
                    st_m    = {1'b1, st_fb[51:0]};
                    st_be   = {2'b00, st_fb[62:52]};
                end
            end
            default: begin
                st_direct = 1'b1;
                st_val    = 64'(i_req.src);
            end
        endcase
    end

    assign step0 = dig_step(r_r, r_n[63:60]);
    assign step1 = dig_step(step0[6:0], r_n[59:56]);

    always_comb begin
        al_sel  = r_q[55];
        al_z    = al_sel ? r_q[55:2] : r_q[54:1];
        al_st   = (al_sel ? (|r_q[1:0]) : r_q[0]) | (r_r != 7'd0);
        al_eo   = r_be - (al_sel ? 13'sd6 : 13'sd7);
        al_sh   = (al_eo > 13'sd0) ? 6'd0 : 6'(13'sd1 - al_eo);
        al_mask = (54'd1 << al_sh) - 54'd1;
        up      = r_z[0] & (r_st | r_z[1]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CV_IDLE:  if (i_req.start) n_state = st_direct ? CV_DONE : CV_NORM;
            CV_NORM:  if (r_m[52]) n_state = r_div ? CV_DIV : CV_DONE;
            CV_DIV:   if (r_cnt == 3'd7) n_state = CV_ALIGN;
            CV_ALIGN: n_state = CV_ROUND;
            CV_ROUND: n_state = CV_DONE;
            CV_DONE:  if (i_req.take) n_state = CV_IDLE;
            default:  n_state = CV_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_sign  = r_sign;
        n_m     = r_m;
        n_be    = r_be;
        n_div   = r_div;
        n_n     = r_n;
        n_q     = r_q;
        n_r     = r_r;
        n_cnt   = r_cnt;
        n_z     = r_z;
        n_st    = r_st;
        n_ef    = r_ef;
        n_value = r_value;
        unique case (r_state)
            CV_IDLE: begin
                n_sign  = st_sign;
                n_m     = st_m;
                n_be    = st_be;
                n_div   = st_div;
                n_value = st_val;
            end
            CV_NORM: begin
                if (r_m[52]) begin
                    n_value = {r_sign, r_be[10:0], r_m[51:0]};
                    n_n     = {2'b00, r_m, 9'b0};
                    n_q     = '0;
                    n_r     = '0;
                    n_cnt   = '0;
                end else if (r_m[52:49] == 4'd0) begin
                    n_m  = {r_m[48:0], 4'b0};
                    n_be = r_be - 13'sd4;
                end else begin
                    n_m  = {r_m[51:0], 1'b0};
                    n_be = r_be - 13'sd1;
                end
            end
            CV_DIV: begin
                n_q   = {r_q[47:0], step0[10:7], step1[10:7]};
                n_r   = step1[6:0];
                n_n   = {r_n[55:0], 8'b0};
                n_cnt = r_cnt + 3'd1;
            end
            CV_ALIGN: begin
                n_z  = al_z >> al_sh;
                n_st = al_st | ((al_z & al_mask) != 54'd0);
                n_ef = (al_eo > 13'sd0) ? al_eo[10:0] : 11'd0;
            end
            CV_ROUND: begin
                n_value = {r_sign, 63'({r_ef, r_z[52:1]}) + 63'(up)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sign  <= n_sign;
        r_m     <= n_m;
        r_be    <= n_be;
        r_div   <= n_div;
        r_n     <= n_n;
        r_q     <= n_q;
        r_r     <= n_r;
        r_cnt   <= n_cnt;
        r_z     <= n_z;
        r_st    <= n_st;
        r_ef    <= n_ef;
        r_value <= n_value;
    end

    assign o_rsp.valid = (r_state == CV_DONE);
    assign o_rsp.value = r_value;

endmodule

`default_nettype wire

// ===== rtl/core/scrp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scrp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    scrp_byte_if.sink                            i_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [scrp_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [63:0]                     i_cfg_data,
    input  wire logic                            i_job_ready,
    output logic                                 o_job_valid,
    output scrp_pkg::t_job                       o_job
);
    import scrp_pkg::*;

    // configuration
    logic [31:0]         r_max_row;
    logic [31:0]         r_cap;
    logic [5:0]          r_mask_bytes;
    logic [63:0]         r_mask [MaskWords];
    logic [MaskBits-1:0] mask_vec;

    // parse state
    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [14:0] r_kind, n_kind;
    logic [28:0] r_len, n_len;
    logic [1:0]  r_lbi, n_lbi;
    logic [28:0] r_seen, n_seen;
    logic [31:0] r_dstart, n_dstart;
    logic [7:0]  r_head [16];
    logic [31:0] r_row, n_row;
    logic        r_row_en, n_row_en;
    logic [31:0] r_cells, n_cells;

    logic        accept, eob;
    logic [7:0]  b;
    logic [7:0]  hv [16];
    logic [31:0] h0, h8, h12;
    logic        stop_now, more, size_end, data_end, fin;
    logic        row_upd, row_stop, row_keep, cell_hit;
    logic [28:0] seen_inc;
    logic        head_we;
    t_job        job;

    assign b      = i_byte.data_byte;
    assign eob    = i_byte.end_of_buffer;
    assign accept = i_byte.valid & i_job_ready;
    assign i_byte.ready = i_job_ready;

    always_comb begin
        for (int w = 0; w < MaskWords; w++) mask_vec[w*64 +: 64] = r_mask[w];
    end

    // current byte shows through at the slot it is about to fill
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            hv[i] = (r_phase == PH_DATA && r_seen == 29'(i)) ? b : r_head[i];
        end
    end
    assign h0  = {hv[3], hv[2], hv[1], hv[0]};
    assign h8  = {hv[11], hv[10], hv[9], hv[8]};
    assign h12 = {hv[15], hv[14], hv[13], hv[12]};

    // decode
    always_comb begin
        stop_now = (r_phase == PH_STOP) || (r_cells >= r_cap);
        more     = 1'b0;
        n_len    = r_len;
        if (r_phase == PH_TYPE0) begin
            n_len = '0;
        end else if (r_phase == PH_SIZE) begin
            if (r_lbi != 2'd3) begin
                n_len = r_len | (29'(b[6:0]) << (5'(r_lbi) * 5'd7));
                more  = b[7];
            end else begin
                n_len = r_len | {b, 21'b0};
            end
        end
        seen_inc = r_seen + 29'd1;
        size_end = (r_phase == PH_SIZE) && !more;
        data_end = (r_phase == PH_DATA) && (seen_inc >= r_len);
        fin      = !stop_now && ((size_end && n_len == 29'd0) || data_end);
        head_we  = !stop_now && (r_phase == PH_DATA) && (r_seen < 29'd16);

        row_upd  = fin && (r_kind == RecRow) && (n_len >= 29'd4);
        row_stop = row_upd && (h0 > r_max_row);
        if (r_mask_bytes == 6'd0) begin
            row_keep = 1'b1;
        end else if ((h0 >> 3) >= 32'(r_mask_bytes) || h0 >= 32'(MaskRows)) begin
            row_keep = 1'b0;
        end else begin
            row_keep = mask_vec[h0[MaskIdxW-1:0]];
        end

        job          = '0;
        job.row      = r_row;
        job.column   = h0;
        job.op       = OP_RAW;
        cell_hit     = 1'b0;
        if (fin && r_kind != RecRow && r_row_en && !(r_row > r_max_row)) begin
            priority if (r_kind == RecRk && n_len >= 29'd12) begin
                cell_hit  = 1'b1;
                job.kind  = KindNumber;
                job.op    = OP_RK;
                job.value = {32'b0, h8};
            end else if ((r_kind == RecReal || r_kind == RecFmlNum) && n_len >= 29'd16) begin
                cell_hit  = 1'b1;
                job.kind  = KindNumber;
                job.value = {h12, h8};
            end else if (r_kind == RecStr && n_len >= 29'd12) begin
                cell_hit  = 1'b1;
                job.kind  = KindStrIdx;
                job.op    = OP_UINT;
                job.value = {32'b0, h8};
            end else if (r_kind == RecFmlStr && n_len >= 29'd12) begin
                cell_hit   = 1'b1;
                job.kind   = KindFmlStr;
                job.offset = r_dstart + 32'd12;
                job.blen   = {h8[30:0], 1'b0};
            end else if (r_kind == RecBool && n_len >= 29'd9) begin
                cell_hit  = 1'b1;
                job.kind  = KindBoolean;
                job.value = (hv[8] != 8'd0) ? DblOne : 64'd0;
            end else begin
                cell_hit = 1'b0;
            end
        end
        n_cells      = r_cells + 32'(cell_hit);
        job.has_cell = cell_hit;
        job.has_sum  = eob;
        job.total    = n_cells;
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (stop_now) begin
            n_phase = PH_STOP;
        end else begin
            unique case (r_phase)
                PH_TYPE0: n_phase = b[7] ? PH_TYPE1 : PH_SIZE;
                PH_TYPE1: n_phase = PH_SIZE;
                PH_SIZE: begin
                    if (!more) n_phase = (n_len == 29'd0) ? PH_TYPE0 : PH_DATA;
                end
                PH_DATA: begin
                    if (data_end) n_phase = row_stop ? PH_STOP : PH_TYPE0;
                end
                default: n_phase = PH_STOP;
            endcase
        end
    end

    // datapath
    always_comb begin
        n_pos    = r_pos + 32'd1;
        n_kind   = r_kind;
        n_lbi    = r_lbi;
        n_seen   = r_seen;
        n_dstart = r_dstart;
        n_row    = r_row;
        n_row_en = r_row_en;
        if (!stop_now) begin
            unique case (r_phase)
                PH_TYPE0: begin
                    n_kind = {8'b0, b[6:0]};
                    n_lbi  = '0;
                end
                PH_TYPE1: n_kind = r_kind | {b, 7'b0};
                PH_SIZE: begin
                    if (r_lbi != 2'd3) n_lbi = r_lbi + 2'd1;
                    if (!more) begin
                        n_dstart = r_pos + 32'd1;
                        n_seen   = '0;
                    end
                end
                PH_DATA: n_seen = seen_inc;
                default: ;
            endcase
        end
        if (row_upd) begin
            n_row = h0;
            if (!row_stop) n_row_en = row_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_row    <= '1;
            r_cap        <= '1;
            r_mask_bytes <= '0;
            for (int w = 0; w < MaskWords; w++) r_mask[w] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgMaxRow:    r_max_row    <= i_cfg_data[31:0];
                CfgCellCap:   r_cap        <= i_cfg_data[31:0];
                CfgMaskBytes: r_mask_bytes <= i_cfg_data[5:0];
                default: begin
                    for (int w = 0; w < MaskWords; w++) begin
                        if (i_cfg_index >= CfgMaskWord0 && i_cfg_index <= CfgMaskWordN
                            && (i_cfg_index - CfgMaskWord0) == CfgIdxW'(w)) begin
                            r_mask[w] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && eob)) begin
            r_phase  <= PH_TYPE0;
            r_pos    <= '0;
            r_kind   <= '0;
            r_len    <= '0;
            r_lbi    <= '0;
            r_seen   <= '0;
            r_dstart <= '0;
            r_row    <= '1;
            r_row_en <= 1'b1;
            r_cells  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_len    <= n_len;
            r_lbi    <= n_lbi;
            r_seen   <= n_seen;
            r_dstart <= n_dstart;
            r_row    <= n_row;
            r_row_en <= n_row_en;
            r_cells  <= n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && head_we) r_head[r_seen[3:0]] <= b;
    end

    assign o_job_valid = accept & (cell_hit | eob);
    assign o_job       = job;

endmodule

`default_nettype wire

// ===== rtl/core/scrp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scrp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire scrp_pkg::t_job i_data,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output scrp_pkg::t_job      o_data
);
    import scrp_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QCntW-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != QCntW'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= QPtrW'(32'(r_wp) + 1 == QDepth ? 0 : 32'(r_wp) + 1);
            if (do_pop)  r_rp <= QPtrW'(32'(r_rp) + 1 == QDepth ? 0 : 32'(r_rp) + 1);
            r_cnt <= r_cnt + QCntW'(do_push) - QCntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/scrp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scrp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire scrp_pkg::t_job i_q_data,
    output logic                o_q_pop,
    scrp_cell_if.source         o_cell
);
    import scrp_pkg::*;

    t_job      r_job;
    logic      r_job_v, r_cell_pend, r_sum_pend, r_started;
    t_conv_req conv_req;
    t_conv_rsp conv_rsp;

    logic        r_out_v;
    logic        r_is_summary, r_is_last;
    logic [31:0] r_row, r_col, r_off, r_blen, r_total;
    logic [2:0]  r_kind;
    logic [63:0] r_value;

    logic needs_conv, cell_rdy, out_free, load_cell, load_sum, job_done, pop;

    assign needs_conv = (r_job.op != OP_RAW);
    assign cell_rdy   = !needs_conv || conv_rsp.valid;
    assign out_free   = !r_out_v || o_cell.ready;
    assign load_cell  = r_job_v && r_cell_pend && cell_rdy && out_free;
    assign load_sum   = r_job_v && !r_cell_pend && r_sum_pend && out_free;
    assign job_done   = (load_cell && !r_sum_pend) || load_sum;
    assign pop        = i_q_valid && (!r_job_v || job_done);
    assign o_q_pop    = pop;

    assign conv_req.start = r_job_v && r_cell_pend && needs_conv && !r_started;
    assign conv_req.take  = load_cell && needs_conv;
    assign conv_req.op    = r_job.op;
    assign conv_req.src   = r_job.value[31:0];

    scrp_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .o_rsp   (conv_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v     <= 1'b0;
            r_cell_pend <= 1'b0;
            r_sum_pend  <= 1'b0;
            r_started   <= 1'b0;
        end else if (pop) begin
            r_job_v     <= 1'b1;
            r_cell_pend <= i_q_data.has_cell;
            r_sum_pend  <= i_q_data.has_sum;
            r_started   <= 1'b0;
        end else begin
            if (job_done)       r_job_v     <= 1'b0;
            if (load_cell)      r_cell_pend <= 1'b0;
            if (load_sum)       r_sum_pend  <= 1'b0;
            if (conv_req.start) r_started   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) r_job <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load_cell || load_sum) begin
            r_out_v <= 1'b1;
        end else if (o_cell.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_cell) begin
            r_is_summary <= 1'b0;
            r_row        <= r_job.row;
            r_col        <= r_job.column;
            r_kind       <= r_job.kind;
            r_value      <= needs_conv ? conv_rsp.value : r_job.value;
            r_off        <= r_job.offset;
            r_blen       <= r_job.blen;
            r_total      <= r_job.total;
            r_is_last    <= !r_sum_pend;
        end else if (load_sum) begin
            r_is_summary <= 1'b1;
            r_row        <= '0;
            r_col        <= '0;
            r_kind       <= '0;
            r_value      <= '0;
            r_off        <= '0;
            r_blen       <= '0;
            r_total      <= r_job.total;
            r_is_last    <= 1'b1;
        end
    end

    assign o_cell.valid            = r_out_v;
    assign o_cell.is_summary       = r_is_summary;
    assign o_cell.cell_row         = r_row;
    assign o_cell.cell_column      = r_col;
    assign o_cell.cell_kind        = r_kind;
    assign o_cell.value_bits       = r_value;
    assign o_cell.text_offset      = r_off;
    assign o_cell.text_byte_length = r_blen;
    assign o_cell.total_cells      = r_total;
    assign o_cell.is_last          = r_is_last;

endmodule

`default_nettype wire

// ===== rtl/core/sheet_cell_record_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      word contents
// i_byte    in   valid/ready    data_byte, end_of_buffer
// o_cell    out  valid/ready    cell or end count result
// i_cfg_*   in   write enable   register index, 64-bit data
//
// the front takes one byte word per cycle; it stalls only while the job
// queue is full. a cell record is at least 11 bytes long
// rk values divided by 100 run through the iterative converter: a radix-16
// long division, two digits a cycle, preceded by normalization when the
// value needs it and followed by an align step and a round step
// integer and index conversions run in the same converter
// reset is synchronous, active low; no clearing pass is needed
// a stalled o_cell keeps its word while the queue keeps taking bytes

module sheet_cell_record_parser_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    scrp_byte_if.sink                         i_byte,
    scrp_cell_if.source                       o_cell,
    input  wire logic                         i_cfg_we,
    input  wire logic [scrp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [63:0]                  i_cfg_data
);
    import scrp_pkg::*;

    // front to queue
    logic job_valid, job_ready;
    t_job job;

    // queue to back
    logic q_valid, q_pop;
    t_job q_data;

    // header decode, row tracking, filters and cell counting
    scrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_ready (job_ready),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // short queue so the byte stream keeps moving during a conversion
    scrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .o_ready (job_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // value conversion and result output register
    scrp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_cell    (o_cell)
    );

endmodule

`default_nettype wire

// ===== tb/sheet_cell_record_parser_top_tb.sv =====
`timescale 1ns / 1ps

module sheet_cell_record_parser_top_tb;
    import scrp_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int HoldCycles = 400;
    localparam int SettleCycles = 64;

    typedef struct {
        bit [7:0] data_byte;
        bit       eob;
    } t_byte_word;

    typedef struct {
        bit        is_summary;
        bit [31:0] row;
        bit [31:0] column;
        bit [2:0]  kind;
        bit [63:0] value;
        bit [31:0] offset;
        bit [31:0] blen;
        bit [31:0] total;
        bit        last;
    } t_cell_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CfgIdxW-1:0]    cfg_index = '0;
    logic [63:0]           cfg_data = '0;

    scrp_byte_if byte_ch ();
    scrp_cell_if cell_ch ();

    sheet_cell_record_parser_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_cell     (cell_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.end_of_buffer = 1'b0;
        cell_ch.ready = 1'b0;
    end

    t_byte_word pending_bytes[$];
    t_byte_word build_bytes[$];
    t_cell_word expected_cells[$];
    int         errors = 0;
    bit         no_idle = 1'b0;
    int         hold_trig = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         cycles = 0;
    bit [7:0]   rec_data[16];

    // ---------------------------------------------------------------
    // predictor: register copies and parser state
    // ---------------------------------------------------------------
    bit [31:0] max_row_q;
    bit [31:0] cell_cap_q;
    bit [5:0]  mask_bytes_q;
    bit [63:0] row_mask_q[MaskWords];

    bit [31:0] pos_q;
    t_phase    phase_q;
    bit [14:0] rec_type_q;
    bit [31:0] rec_len_q;
    bit [1:0]  len_idx_q;
    bit [31:0] seen_q;
    bit [31:0] data_start_q;
    bit [7:0]  head_q[16];
    bit [31:0] cur_row_q;
    bit        row_on_q;
    bit [31:0] emitted_q;

    function automatic void clear_parser();
        pos_q = 0;
        phase_q = PH_TYPE0;
        rec_type_q = 0;
        rec_len_q = 0;
        len_idx_q = 0;
        seen_q = 0;
        data_start_q = 0;
        foreach (head_q[i]) head_q[i] = 8'h00;
        cur_row_q = 32'hFFFF_FFFF;
        row_on_q = 1'b1;
        emitted_q = 0;
    endfunction

    // little-endian word out of the captured record head
    function automatic bit [31:0] head_word(int off);
        return {head_q[(off + 3) & 15], head_q[(off + 2) & 15],
                head_q[(off + 1) & 15], head_q[off & 15]};
    endfunction

    function automatic bit [63:0] rk_to_double(bit [31:0] rk);
        real    v;
        longint s;
        if (rk[1]) begin
            s = longint'(rk >> 2);
            if (rk[31]) s -= longint'(1) << 30;
            v = real'(s);
        end else begin
            v = $bitstoreal({rk & 32'hFFFF_FFFC, 32'h0});
        end
        if (rk[0]) v = v / 100.0;
        return $realtobits(v);
    endfunction

    function automatic bit row_selected(bit [31:0] row);
        if (mask_bytes_q == 0) return 1'b1;
        if ((row >> 3) >= mask_bytes_q || row >= MaskRows) return 1'b0;
        return row_mask_q[row >> 6][row & 63];
    endfunction

    // acts on a finished record, returns 1 when it yields a cell
    function automatic bit close_record(output t_cell_word c);
        bit [31:0] len;
        len = rec_len_q;
        c = '{default: '0};
        phase_q = PH_TYPE0;
        if (rec_type_q == RecRow) begin
            if (len >= 4) begin
                cur_row_q = head_word(0);
                if (cur_row_q > max_row_q) begin
                    phase_q = PH_STOP;
                    return 1'b0;
                end
                row_on_q = row_selected(cur_row_q);
            end
            return 1'b0;
        end
        if (!row_on_q || cur_row_q > max_row_q) return 1'b0;
        if (rec_type_q == RecRk && len >= 12) begin
            c.kind = KindNumber;
            c.value = rk_to_double(head_word(8));
        end else if ((rec_type_q == RecReal || rec_type_q == RecFmlNum) && len >= 16) begin
            c.kind = KindNumber;
            c.value = {head_word(12), head_word(8)};
        end else if (rec_type_q == RecStr && len >= 12) begin
            c.kind = KindStrIdx;
            c.value = $realtobits(real'(longint'(head_word(8))));
        end else if (rec_type_q == RecFmlStr && len >= 12) begin
            c.kind = KindFmlStr;
            c.offset = data_start_q + 12;
            c.blen = head_word(8) * 2;
        end else if (rec_type_q == RecBool && len >= 9) begin
            c.kind = KindBoolean;
            c.value = (head_q[8] != 0) ? DblOne : 64'h0;
        end else begin
            return 1'b0;
        end
        emitted_q++;
        c.row = cur_row_q;
        c.column = head_word(0);
        c.total = emitted_q;
        c.last = 1'b1;
        return 1'b1;
    endfunction

    function automatic void predict_byte(bit [7:0] b, bit eob);
        t_cell_word c;
        t_cell_word s;
        bit         got;
        bit         more;
        got = 1'b0;
        if (phase_q == PH_STOP || emitted_q >= cell_cap_q) begin
            phase_q = PH_STOP;
        end else begin
            case (phase_q)
                PH_TYPE0: begin
                    rec_type_q = {8'h00, b[6:0]};
                    phase_q = b[7] ? PH_TYPE1 : PH_SIZE;
                    rec_len_q = 0;
                    len_idx_q = 0;
                end
                PH_TYPE1: begin
                    rec_type_q = rec_type_q | (15'(b) << 7);
                    phase_q = PH_SIZE;
                end
                PH_SIZE: begin
                    more = 1'b0;
                    if (len_idx_q < 3) begin
                        rec_len_q = rec_len_q | (32'(b[6:0]) << (7 * len_idx_q));
                        more = b[7];
                        len_idx_q++;
                    end else begin
                        rec_len_q = rec_len_q | (32'(b) << 21);
                    end
                    if (!more) begin
                        data_start_q = pos_q + 1;
                        seen_q = 0;
                        if (rec_len_q == 0) got = close_record(c);
                        else phase_q = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (seen_q < 16) head_q[seen_q] = b;
                    seen_q++;
                    if (seen_q >= rec_len_q) got = close_record(c);
                end
                default: phase_q = PH_STOP;
            endcase
        end
        pos_q++;
        if (got) begin
            if (eob) c.last = 1'b0;
            expected_cells.push_back(c);
        end
        if (eob) begin
            s = '{default: '0};
            s.is_summary = 1'b1;
            s.total = emitted_q;
            s.last = 1'b1;
            expected_cells.push_back(s);
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------
    // byte driver: pops pending words, predicts on each accepted word
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        t_byte_word w;
        bit         idle;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.data_byte, byte_ch.end_of_buffer);
            if (!byte_ch.valid || byte_ch.ready) begin
                idle = !no_idle && ($urandom_range(0, 99) < 14);
                if (pending_bytes.size() > 0 && !idle) begin
                    w = pending_bytes.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.data_byte <= w.data_byte;
                    byte_ch.end_of_buffer <= w.eob;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, restarted whenever hold_trig moves
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HoldCycles;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // cell monitor: compares each accepted word with the oldest expected one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : cell_monitor
        t_cell_word got;
        t_cell_word want;
        if (!i_rst_n) begin
            cell_ch.ready <= 1'b0;
        end else begin
            if (cell_ch.valid && cell_ch.ready) begin
                got.is_summary = cell_ch.is_summary;
                got.row = cell_ch.cell_row;
                got.column = cell_ch.cell_column;
                got.kind = cell_ch.cell_kind;
                got.value = cell_ch.value_bits;
                got.offset = cell_ch.text_offset;
                got.blen = cell_ch.text_byte_length;
                got.total = cell_ch.total_cells;
                got.last = cell_ch.is_last;
                if (expected_cells.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word: %p", got);
                end else begin
                    want = expected_cells.pop_front();
                    if (got.is_summary !== want.is_summary || got.row !== want.row ||
                        got.column !== want.column || got.kind !== want.kind ||
                        got.value !== want.value || got.offset !== want.offset ||
                        got.blen !== want.blen || got.total !== want.total ||
                        got.last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            cell_ch.ready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= 14);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    function automatic void add_byte(bit [7:0] b);
        t_byte_word w;
        w.data_byte = b;
        w.eob = 1'b0;
        build_bytes.push_back(w);
    endfunction

    // header plus n_out data bytes of a record of length len
    function automatic void add_record(int unsigned typ, int unsigned len, int unsigned n_out);
        int unsigned nmin;
        int unsigned nb;
        bit [7:0]    b;
        if (typ > 127 || $urandom_range(0, 9) == 0) begin
            add_byte(8'(typ & 32'h7F) | 8'h80);
            add_byte(8'(typ >> 7));
        end else begin
            add_byte(8'(typ));
        end
        nmin = (len < (1 << 7)) ? 1 : (len < (1 << 14)) ? 2 : (len < (1 << 21)) ? 3 : 4;
        nb = nmin;
        // padded size coding with empty continuation groups
        if ($urandom_range(0, 3) == 0) nb = nmin + $urandom_range(0, 4 - nmin);
        for (int i = 0; i < nb; i++) begin
            if (i == 3) begin
                b = 8'(len >> 21);
            end else begin
                b = 8'((len >> (7 * i)) & 32'h7F);
                if (i < nb - 1) b = b | 8'h80;
            end
            add_byte(b);
        end
        for (int i = 0; i < n_out; i++)
            add_byte(i < 16 ? rec_data[i] : 8'($urandom));
    endfunction

    function automatic void set_word(int off, bit [31:0] v);
        for (int i = 0; i < 4; i++) rec_data[off + i] = v[8*i +: 8];
    endfunction

    function automatic bit [31:0] rand_rk();
        bit [31:0] rk;
        rk = $urandom;
        // float form mostly with sane exponents
        if (!rk[1] && $urandom_range(0, 1)) rk[30:20] = 11'($urandom_range(900, 1150));
        return rk;
    endfunction

    function automatic void fill_cell(int unsigned typ);
        foreach (rec_data[i]) rec_data[i] = 8'($urandom);
        if (typ == RecRk) set_word(8, rand_rk());
        if (typ == RecBool && $urandom_range(0, 3) != 0) rec_data[8] = 8'($urandom_range(0, 1));
    endfunction

    function automatic int unsigned min_len(int unsigned typ);
        case (typ)
            RecRk, RecStr, RecFmlStr: return 12;
            RecReal, RecFmlNum:       return 16;
            RecBool:                  return 9;
            default:                  return 4;
        endcase
    endfunction

    task automatic flush_buffer();
        if (build_bytes.size() == 0) add_byte(8'($urandom));
        build_bytes[build_bytes.size() - 1].eob = 1'b1;
        foreach (build_bytes[i]) pending_bytes.push_back(build_bytes[i]);
        build_bytes.delete();
    endtask

    // one sheet buffer of random records, ending with the eob mark
    task automatic random_buffer(int nrec, int unsigned row_hi);
        int unsigned cell_types[6];
        int unsigned typ;
        int unsigned len;
        int          r;
        cell_types = '{RecRk, RecReal, RecStr, RecFmlStr, RecFmlNum, RecBool};
        for (int n = 0; n < nrec; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                foreach (rec_data[i]) rec_data[i] = 8'($urandom);
                set_word(0, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, row_hi));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4 + $urandom_range(0, 2);
                add_record(RecRow, len, len);
            end else if (r < 88) begin
                typ = cell_types[$urandom_range(0, 5)];
                fill_cell(typ);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, min_len(typ) - 1)
                                                  : min_len(typ) + $urandom_range(0, 3);
                add_record(typ, len, len);
            end else begin
                foreach (rec_data[i]) rec_data[i] = 8'($urandom);
                len = $urandom_range(0, 20);
                add_record($urandom_range(0, 32767), len, len);
            end
        end
        // sometimes the buffer ends inside an open record
        if ($urandom_range(0, 5) == 0) begin
            fill_cell(RecRk);
            if ($urandom_range(0, 1)) add_record(RecRk, 12, $urandom_range(0, 11));
            else add_record($urandom_range(0, 32767), $urandom, $urandom_range(0, 6));
        end
        flush_buffer();
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [63:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx == CfgMaxRow) max_row_q = v[31:0];
        else if (idx == CfgCellCap) cell_cap_q = v[31:0];
        else if (idx == CfgMaskBytes) mask_bytes_q = v[5:0];
        else if (idx >= CfgMaskWord0 && idx <= CfgMaskWordN) row_mask_q[idx - CfgMaskWord0] = v;
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || byte_ch.valid || expected_cells.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_masks(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3);
        cfg_write(CfgMaskWord0, w0);
        cfg_write(CfgIdxW'(CfgMaskWord0 + 1), w1);
        cfg_write(CfgIdxW'(CfgMaskWord0 + 2), w2);
        cfg_write(CfgMaskWordN, w3);
    endtask

    initial begin
        int phase_bytes;
        max_row_q = 32'hFFFF_FFFF;
        cell_cap_q = 32'hFFFF_FFFF;
        mask_bytes_q = 0;
        foreach (row_mask_q[i]) row_mask_q[i] = 64'h0;
        clear_parser();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a cell before any row, every record type, rk forms
        fill_cell(RecRk);
        set_word(0, 32'hFFFF_FFFF);
        set_word(8, {30'd7, 2'b10});
        add_record(RecRk, 12, 12);
        set_word(0, 32'd2);
        add_record(RecRow, 4, 4);
        fill_cell(RecRk);
        set_word(8, {-30'sd12345, 2'b11});
        add_record(RecRk, 12, 12);
        set_word(8, 32'h3FF0_0001);
        add_record(RecRk, 12, 12);
        fill_cell(RecReal);
        add_record(RecReal, 16, 16);
        add_record(RecFmlNum, 16, 16);
        set_word(8, 32'hFFFF_FFFF);
        add_record(RecStr, 12, 12);
        set_word(8, 32'h8000_0001);
        add_record(RecFmlStr, 12, 12);
        rec_data[8] = 8'h01;
        add_record(RecBool, 9, 9);
        rec_data[8] = 8'h00;
        add_record(RecBool, 9, 9);
        add_record(RecRk, 0, 0);
        rec_data[8] = 8'hFF;
        add_record(RecBool, 9, 9);
        flush_buffer();
        add_byte(8'hFF);
        flush_buffer();
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    cfg_write(CfgMaskBytes, 64'd32);
                    set_masks({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom});
                end
                2: begin
                    cfg_write(CfgMaxRow, 64'd200);
                    cfg_write(CfgCellCap, 64'd40);
                    cfg_write(CfgMaskBytes, 64'($urandom_range(1, 31)));
                    no_idle = 1'b1;
                end
                3: begin
                    cfg_write(CfgMaxRow, 64'd0);
                    cfg_write(CfgCellCap, 64'd0);
                    cfg_write(CfgMaskBytes, 64'd0);
                    no_idle = 1'b0;
                end
                4: begin
                    cfg_write(CfgMaxRow, 64'($urandom_range(100, 300)));
                    cfg_write(CfgCellCap, 64'd3);
                    cfg_write(CfgMaskBytes, 64'd32);
                    set_masks('1, '1, '1, '1);
                end
                5: begin
                    cfg_write(CfgMaxRow, 64'hFFFF_FFFF);
                    cfg_write(CfgCellCap, 64'hFFFF_FFFF);
                    cfg_write(CfgMaskBytes, 64'd0);
                    set_masks('0, '0, '0, '0);
                end
                default: ;
            endcase
            if (p != 0) cfg_done();
            // phase 5 holds the receiver off while bytes keep coming
            if (p == 5) hold_trig++;
            phase_bytes = pending_bytes.size();
            while (pending_bytes.size() - phase_bytes < ((p == 3) ? 50 : 130))
                random_buffer($urandom_range(2, 14), (p == 2 || p == 4) ? 300 : 260);
            drain();
        end

        if (errors == 0 && expected_cells.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sheet_cell_record_parser_top.f =====
rtl/core/scrp_pkg.sv
rtl/core/scrp_byte_if.sv
rtl/core/scrp_cell_if.sv
rtl/core/scrp_conv.sv
rtl/core/scrp_front.sv
rtl/core/scrp_queue.sv
rtl/core/scrp_back.sv
rtl/core/sheet_cell_record_parser_top.sv
tb/sheet_cell_record_parser_top_tb.sv
